// ----- src/pcat_pkg.sv -----
// shared types and constants for the partition carve and translate block
`default_nettype none
package pcat_pkg;

  localparam int unsigned BLOCK_BITS = 48;

  typedef logic [BLOCK_BITS-1:0] blk_t;

  typedef enum logic [1:0] {
    FN_CARVE    = 2'd0,
    FN_U2L      = 2'd1,
    FN_L2U      = 2'd2,
    FN_CLEAR    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_EXISTS   = 3'd2,
    ST_RANGE    = 3'd3,
    ST_UNKNOWN  = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  localparam logic CFG_LAYOUT_START  = 1'b0;
  localparam logic CFG_LAYOUT_BLOCKS = 1'b1;

  typedef struct packed {
    func_e      func;
    logic [7:0] part_id;
    blk_t       carve_blocks;
    logic       take_all;
    logic       from_end;
    blk_t       user_base;
    blk_t       block_number;
    logic       bypass;
  } in_item_t;

  typedef struct packed {
    status_e status;
    blk_t    result_block;
    blk_t    free_left;
  } out_item_t;

  typedef struct packed {
    logic [7:0] id;
    blk_t       offset;
    blk_t       base;
    blk_t       length;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan_en;
    logic diff_en;
    logic exec;
  } cmd_t;

endpackage
`default_nettype wire

// ----- src/pcat_ctrl.sv -----
// sequencer: accept, table scan, offset difference, execute
`default_nettype none
module pcat_ctrl #(
  parameter int unsigned MAX_PARTITIONS = 8,
  parameter int unsigned IW = 3
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_stall_o,
  input  wire logic            out_busy_i,
  output      pcat_pkg::cmd_t  cmd_o,
  output      logic [IW-1:0]   scan_idx_o
);
  import pcat_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PARTITIONS + 1);
  localparam logic [CW-1:0] LAST = CW'(MAX_PARTITIONS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_TRANS,
    S_EXEC
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   cnt_q;
  logic            accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign scan_idx_o = cnt_q[IW-1:0];

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = accept;
    cmd_o.scan_en = (state_q == S_SCAN) && (cnt_q != LAST);
    cmd_o.diff_en = (state_q == S_TRANS);
    cmd_o.exec    = (state_q == S_EXEC) && !out_busy_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) state_q <= S_PREP;
        end
        S_PREP: begin
          cnt_q   <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          // staying in S_SCAN while cnt_q equals LAST lets the last registered read be compared
          if (cnt_q == LAST) state_q <= S_TRANS;
          else cnt_q <= cnt_q + 1'b1;
        end
        S_TRANS: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (!out_busy_i) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_PREP)
    else $error("accepted item did not start preparation");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> cnt_q <= LAST)
    else $error("scan counter past table depth");

  a_exec_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> state_q == S_IDLE)
    else $error("execute did not return to idle");

endmodule
`default_nettype wire

// ----- src/pcat_dp.sv -----
// datapath: free range, partition table, scan compare, result register
`default_nettype none
module pcat_dp #(
  parameter int unsigned MAX_PARTITIONS = 8,
  parameter int unsigned IW = 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pcat_pkg::in_item_t  in_item_i,
  input  wire pcat_pkg::cmd_t      cmd_i,
  input  wire logic [IW-1:0]       scan_idx_i,
  output      logic                out_busy_o,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      pcat_pkg::out_item_t out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire pcat_pkg::blk_t      cfg_data_i
);
  import pcat_pkg::*;

  // configuration and free range
  blk_t lay_start_q, lay_blocks_q, lay_end_q;
  blk_t free_first_q, free_last_q;
  logic [BLOCK_BITS:0] lay_sum;

  // partition table
  logic [MAX_PARTITIONS-1:0] valid_q;
  entry_t entry_mem [MAX_PARTITIONS];
  entry_t rd_q;
  logic [IW-1:0] rd_tag_q;
  logic rd_vld_q;

  // current item and scan results
  in_item_t item_q;
  logic hit_q, slot_fnd_q;
  entry_t hit_e_q;
  logic [IW-1:0] slot_q;

  // carve preparation
  blk_t avail_q, cnt_eff_q, off_q;
  logic nspc_q;

  // translate preparation
  logic [BLOCK_BITS:0] diff_q;
  blk_t other_q, len_q;

  logic out_valid_q;
  out_item_t out_q, res;
  logic carve_ok;

  assign lay_sum = {1'b0, lay_start_q} + {1'b0, lay_blocks_q};

  // derived values, always recomputed; inputs are stable while they are used
  always_ff @(posedge clk_i) begin
    lay_end_q <= lay_sum[BLOCK_BITS] ? '1 : lay_sum[BLOCK_BITS-1:0];
    avail_q   <= (free_last_q < free_first_q) ? '0 : free_last_q - free_first_q;
    if (item_q.take_all) begin
      nspc_q    <= (avail_q == '0);
      cnt_eff_q <= avail_q;
    end else begin
      nspc_q    <= (item_q.carve_blocks > avail_q);
      cnt_eff_q <= item_q.carve_blocks;
    end
    off_q <= item_q.from_end ? free_last_q - cnt_eff_q : free_first_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_item_i;
    if (cmd_i.scan_en) rd_q <= entry_mem[scan_idx_i];
    rd_tag_q <= scan_idx_i;
    if (rd_vld_q && !hit_q) hit_e_q <= rd_q;
    if (cmd_i.scan_en && !slot_fnd_q) slot_q <= scan_idx_i;
    if (cmd_i.diff_en) begin
      if (item_q.func == FN_U2L) begin
        diff_q  <= {1'b0, item_q.block_number} - {1'b0, hit_e_q.base};
        other_q <= hit_e_q.offset;
      end else begin
        diff_q  <= {1'b0, item_q.block_number} - {1'b0, hit_e_q.offset};
        other_q <= hit_e_q.base;
      end
      len_q <= hit_e_q.length;
    end
    if (cmd_i.exec) out_q <= res;
    if (cmd_i.exec && carve_ok) begin
      entry_mem[slot_q] <= '{id: item_q.part_id, offset: off_q,
                             base: item_q.user_base, length: cnt_eff_q};
    end
  end

  assign carve_ok = (item_q.func == FN_CARVE) && !nspc_q && !hit_q && slot_fnd_q;

  always_comb begin
    res.status       = ST_OK;
    res.result_block = '0;
    res.free_left    = avail_q;
    case (item_q.func)
      FN_CLEAR: begin
        res.free_left = lay_end_q - lay_start_q;
      end
      FN_CARVE: begin
        if (nspc_q) res.status = ST_NO_SPACE;
        else if (hit_q) res.status = ST_EXISTS;
        else if (!slot_fnd_q) res.status = ST_FULL;
        else begin
          res.result_block = off_q;
          res.free_left    = avail_q - cnt_eff_q;
        end
      end
      FN_U2L, FN_L2U: begin
        if (item_q.bypass) res.result_block = item_q.block_number;
        else if (!hit_q) res.status = ST_UNKNOWN;
        else if (diff_q[BLOCK_BITS] || diff_q[BLOCK_BITS-1:0] >= len_q) res.status = ST_RANGE;
        else res.result_block = other_q + diff_q[BLOCK_BITS-1:0];
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lay_start_q  <= '0;
      lay_blocks_q <= '0;
      free_first_q <= '0;
      free_last_q  <= '0;
      valid_q      <= '0;
      rd_vld_q     <= 1'b0;
      hit_q        <= 1'b0;
      slot_fnd_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LAYOUT_START:  lay_start_q  <= cfg_data_i;
          CFG_LAYOUT_BLOCKS: lay_blocks_q <= cfg_data_i;
          default:           lay_start_q  <= cfg_data_i;
        endcase
      end
      rd_vld_q <= cmd_i.scan_en;
      if (cmd_i.load) begin
        hit_q      <= 1'b0;
        slot_fnd_q <= 1'b0;
      end else begin
        // lowest matching valid entry wins
        if (rd_vld_q && !hit_q && valid_q[rd_tag_q] && rd_q.id == item_q.part_id) begin
          hit_q <= 1'b1;
        end
        // lowest free slot
        if (cmd_i.scan_en && !slot_fnd_q && !valid_q[scan_idx_i]) slot_fnd_q <= 1'b1;
      end
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
        if (item_q.func == FN_CLEAR) begin
          free_first_q <= lay_start_q;
          free_last_q  <= lay_end_q;
          valid_q      <= '0;
        end else if (carve_ok) begin
          valid_q[slot_q] <= 1'b1;
          if (item_q.from_end) free_last_q <= off_q;
          else free_first_q <= free_first_q + cnt_eff_q;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_busy_o  = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && item_q.func == FN_CLEAR |=> valid_q == '0)
    else $error("table not emptied by clear");

  a_carve_adds_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && carve_ok |=> $countones(valid_q) == $past($countones(valid_q)) + 1)
    else $error("carve did not add exactly one entry");

endmodule
`default_nettype wire

// ----- src/partition_carve_and_translate.sv -----
// each item runs prepare, id scan, offset difference and execute, then its result is valid
// the input stalls until the previous item has left the execute state
// the time is set by the id scan, one table entry per cycle through one read port
// the result register frees the input side while a result waits to be taken
// reset (rst_ni, async low) empties the free range and the table and zeroes both registers
`default_nettype none
module partition_carve_and_translate #(
  parameter int unsigned MAX_PARTITIONS = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire pcat_pkg::in_item_t  in_item_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      pcat_pkg::out_item_t out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire pcat_pkg::blk_t      cfg_data_i
);
  import pcat_pkg::*;

  localparam int unsigned IW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;

  cmd_t          cmd;
  logic [IW-1:0] scan_idx;
  logic          out_busy;

  pcat_ctrl #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .IW             (IW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_busy_i (out_busy),
    .cmd_o      (cmd),
    .scan_idx_o (scan_idx)
  );

  pcat_dp #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .IW             (IW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .scan_idx_i  (scan_idx),
    .out_busy_o  (out_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule
`default_nettype wire
